[hw/rtl/xzpsd_pkg.sv]
// Shared constants and types for the XZ point-to-segment distance block.
// Has no dependencies; every other file in hw/rtl uses it.
package xzpsd_pkg;

  // Default coordinate width (signed Q12.12).
  localparam int COORD_BITS_DEF = 24;
  // Fraction bits of the projection parameter t (unsigned Q1.30).
  localparam int T_BITS = 30;
  // Width and reset value of the degenerate-length threshold.
  localparam int THRESH_BITS = 24;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 24'd1678;
  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Classification of a request.
  typedef enum logic [1:0] {
    REGION_BEFORE     = 2'd0,
    REGION_BEYOND     = 2'd1,
    REGION_INTERIOR   = 2'd2,
    REGION_DEGENERATE = 2'd3
  } region_t;

  // Handshake between a producer and the queue.
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

[hw/rtl/xzpsd_front.sv]
// Front part: forms differences, dot products and squared length, then classifies.
// Depends on xzpsd_pkg.
module xzpsd_front #(
  parameter int COORD_BITS = xzpsd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        point_x,
  input  logic signed [COORD_BITS-1:0]        point_z,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_z,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_z,
  input  logic [xzpsd_pkg::THRESH_BITS-1:0]   threshold,
  output xzpsd_pkg::q_wr_t                    q_wr_o,
  input  logic                                q_full,
  output logic [4*COORD_BITS+2*(COORD_BITS+1)+2-1:0] q_side,
  output logic [2*COORD_BITS+2-1:0]           q_d1,
  output logic [2*COORD_BITS+2-1:0]           q_len
);
  localparam int CB = COORD_BITS;
  localparam int DB = CB + 1;
  localparam int PB = 2 * DB;
  localparam int TH = xzpsd_pkg::THRESH_BITS;
  localparam int CW = PB + 1 + TH;

  logic en;
  logic v0_r, v1_r, v2_r;

  logic signed [CB-1:0] p0x_r, p0z_r, s0x_r, s0z_r, e0x_r, e0z_r;
  logic signed [DB-1:0] dx0_r, dz0_r, ax0_r, az0_r, bx0_r, bz0_r;

  logic signed [CB-1:0] p1x_r, p1z_r, s1x_r, s1z_r, e1x_r, e1z_r;
  logic signed [DB-1:0] dx1_r, dz1_r;
  logic signed [PB-1:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;

  logic signed [CB-1:0] p2x_r, p2z_r, s2x_r, s2z_r, e2x_r, e2z_r;
  logic signed [DB-1:0] dx2_r, dz2_r;
  logic signed [PB:0]   d1_r, d2_r, len_r;

  xzpsd_pkg::region_t   region;
  logic signed [CB-1:0] base_x, base_z;
  logic                 degen;

  // The whole front moves together unless its last stage is blocked by a full queue.
  assign en       = !v2_r || !q_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Stage 0 takes differences, stage 1 the products, stage 2 the sums.
  always_ff @(posedge clk) begin
    if (en) begin
      p0x_r <= point_x;
      p0z_r <= point_z;
      s0x_r <= start_x;
      s0z_r <= start_z;
      e0x_r <= end_x;
      e0z_r <= end_z;
      dx0_r <= DB'(end_x) - DB'(start_x);
      dz0_r <= DB'(end_z) - DB'(start_z);
      ax0_r <= DB'(point_x) - DB'(start_x);
      az0_r <= DB'(point_z) - DB'(start_z);
      bx0_r <= DB'(end_x) - DB'(point_x);
      bz0_r <= DB'(end_z) - DB'(point_z);

      p1x_r <= p0x_r;
      p1z_r <= p0z_r;
      s1x_r <= s0x_r;
      s1z_r <= s0z_r;
      e1x_r <= e0x_r;
      e1z_r <= e0z_r;
      dx1_r <= dx0_r;
      dz1_r <= dz0_r;
      m1_r  <= dx0_r * ax0_r;
      m2_r  <= dz0_r * az0_r;
      m3_r  <= dx0_r * bx0_r;
      m4_r  <= dz0_r * bz0_r;
      m5_r  <= dx0_r * dx0_r;
      m6_r  <= dz0_r * dz0_r;

      p2x_r <= p1x_r;
      p2z_r <= p1z_r;
      s2x_r <= s1x_r;
      s2z_r <= s1z_r;
      e2x_r <= e1x_r;
      e2z_r <= e1z_r;
      dx2_r <= dx1_r;
      dz2_r <= dz1_r;
      d1_r  <= (PB+1)'(m1_r) + (PB+1)'(m2_r);
      d2_r  <= (PB+1)'(m3_r) + (PB+1)'(m4_r);
      len_r <= (PB+1)'(m5_r) + (PB+1)'(m6_r);
    end
  end

  // Classification: before and beyond come ahead of the degenerate test.
  assign degen = (len_r == '0) ||
                 (CW'($unsigned(len_r)) < CW'(threshold));

  always_comb begin
    if (d1_r[PB]) begin
      region = xzpsd_pkg::REGION_BEFORE;
      base_x = s2x_r;
      base_z = s2z_r;
    end else if (d2_r[PB]) begin
      region = xzpsd_pkg::REGION_BEYOND;
      base_x = e2x_r;
      base_z = e2z_r;
    end else if (degen) begin
      region = xzpsd_pkg::REGION_DEGENERATE;
      base_x = s2x_r;
      base_z = s2z_r;
    end else begin
      region = xzpsd_pkg::REGION_INTERIOR;
      base_x = s2x_r;
      base_z = s2z_r;
    end
  end

  // Request to the queue.
  assign q_wr_o.push = v2_r && !q_full;
  assign q_wr_o.full = q_full;
  assign q_side = {p2x_r, p2z_r, base_x, base_z, dx2_r, dz2_r, region};
  assign q_d1   = d1_r[PB-1:0];
  assign q_len  = len_r[PB-1:0];

endmodule

[hw/rtl/xzpsd_queue.sv]
// Short FIFO that decouples the front part from the back part.
// Depends on xzpsd_pkg.
module xzpsd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = xzpsd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  xzpsd_pkg::q_wr_t  q_wr_i,
  output logic              full,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              pop,
  output logic              empty,
  output logic [WIDTH-1:0]  rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [NW-1:0]    count_r;
  logic             do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rptr_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (q_wr_i.push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + NW'(q_wr_i.push) - NW'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (q_wr_i.push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/xzpsd_back.sv]
// Back part: pipelined restoring division, offset rounding and squared distance.
// Depends on xzpsd_pkg.
module xzpsd_back #(
  parameter int COORD_BITS = xzpsd_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [4*COORD_BITS+2*(COORD_BITS+1)+2-1:0] q_side,
  input  logic [2*COORD_BITS+2-1:0]            q_d1,
  input  logic [2*COORD_BITS+2-1:0]            q_len,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2*COORD_BITS+2-1:0]            distance_squared,
  output logic signed [COORD_BITS-1:0]         closest_x,
  output logic signed [COORD_BITS-1:0]         closest_z,
  output logic [1:0]                           region
);
  localparam int CB  = COORD_BITS;
  localparam int DB  = CB + 1;
  localparam int LB  = 2 * CB + 2;
  localparam int RB  = LB + 1;
  localparam int TB  = xzpsd_pkg::T_BITS;
  localparam int QB  = TB + 1;
  localparam int NS  = QB;
  localparam int MB  = DB + QB;
  localparam int OB  = DB + 2;
  localparam int SQ  = 2 * DB;
  localparam int SBW = 4 * CB + 2 * DB + 2;

  logic en;

  // Divider stages.
  logic             sv_r   [NS];
  logic [RB-1:0]    rem_r  [NS];
  logic [QB-1:0]    quo_r  [NS];
  logic [LB-1:0]    len_r  [NS];
  logic [SBW-1:0]   side_r [NS];

  logic [RB-1:0]    st_rin  [NS];
  logic [QB-1:0]    st_qin  [NS];
  logic [LB-1:0]    st_len  [NS];
  logic [SBW-1:0]   st_side [NS];
  logic             st_v    [NS];

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // Each divider stage settles one quotient bit with one compare and subtract.
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic          ge;
    logic [RB-1:0] rout;
    if (k == 0) begin : g_first
      assign st_rin[k]  = {1'b0, q_d1};
      assign st_qin[k]  = '0;
      assign st_len[k]  = q_len;
      assign st_side[k] = q_side;
      assign st_v[k]    = !q_empty;
    end else begin : g_next
      assign st_rin[k]  = {rem_r[k-1][RB-2:0], 1'b0};
      assign st_qin[k]  = quo_r[k-1];
      assign st_len[k]  = len_r[k-1];
      assign st_side[k] = side_r[k-1];
      assign st_v[k]    = sv_r[k-1];
    end
    assign ge   = st_rin[k] >= {1'b0, st_len[k]};
    assign rout = ge ? st_rin[k] - {1'b0, st_len[k]} : st_rin[k];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rout;
        quo_r[k]  <= {st_qin[k][QB-2:0], ge};
        len_r[k]  <= st_len[k];
        side_r[k] <= st_side[k];
      end
    end
  end

  // Unpack the side data leaving the divider.
  logic signed [CB-1:0] dv_px, dv_pz, dv_bx, dv_bz;
  logic signed [DB-1:0] dv_dx, dv_dz;
  logic [1:0]           dv_reg;
  logic [DB-1:0]        abs_dx, abs_dz;

  assign {dv_px, dv_pz, dv_bx, dv_bz, dv_dx, dv_dz, dv_reg} = side_r[NS-1];
  assign abs_dx = dv_dx[DB-1] ? DB'(-dv_dx) : DB'(dv_dx);
  assign abs_dz = dv_dz[DB-1] ? DB'(-dv_dz) : DB'(dv_dz);

  // Multiply stage: magnitude of t times each direction component.
  logic                 m_v_r;
  logic [MB-1:0]        m_magx_r, m_magz_r;
  logic                 m_negx_r, m_negz_r;
  logic signed [CB-1:0] m_px_r, m_pz_r, m_bx_r, m_bz_r;
  logic [1:0]           m_reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= sv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_magx_r <= MB'(abs_dx) * MB'(quo_r[NS-1]);
      m_magz_r <= MB'(abs_dz) * MB'(quo_r[NS-1]);
      m_negx_r <= dv_dx[DB-1];
      m_negz_r <= dv_dz[DB-1];
      m_px_r   <= dv_px;
      m_pz_r   <= dv_pz;
      m_bx_r   <= dv_bx;
      m_bz_r   <= dv_bz;
      m_reg_r  <= dv_reg;
    end
  end

  // Round to nearest with ties away from zero; only the interior case moves off the base.
  logic [MB-1:0]        rnd_x, rnd_z;
  logic signed [OB-1:0] off_x, off_z;
  logic signed [CB-1:0] cx, cz;
  logic                 interior;

  assign interior = (m_reg_r == xzpsd_pkg::REGION_INTERIOR);
  assign rnd_x = (m_magx_r + (MB'(1) << (TB - 1))) >> TB;
  assign rnd_z = (m_magz_r + (MB'(1) << (TB - 1))) >> TB;

  always_comb begin
    off_x = '0;
    off_z = '0;
    if (interior) begin
      off_x = m_negx_r ? -$signed(OB'(rnd_x)) : $signed(OB'(rnd_x));
      off_z = m_negz_r ? -$signed(OB'(rnd_z)) : $signed(OB'(rnd_z));
    end
  end

  assign cx = CB'(OB'(m_bx_r) + off_x);
  assign cz = CB'(OB'(m_bz_r) + off_z);

  // Closest point stage.
  logic                 c_v_r;
  logic signed [CB-1:0] c_cx_r, c_cz_r;
  logic signed [DB-1:0] c_ox_r, c_oz_r;
  logic [1:0]           c_reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cx_r  <= cx;
      c_cz_r  <= cz;
      c_ox_r  <= DB'(m_px_r) - DB'(cx);
      c_oz_r  <= DB'(m_pz_r) - DB'(cz);
      c_reg_r <= m_reg_r;
    end
  end

  // Square stage.
  logic                 s_v_r;
  logic signed [SQ-1:0] s_sqx_r, s_sqz_r;
  logic signed [CB-1:0] s_cx_r, s_cz_r;
  logic [1:0]           s_reg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sqx_r <= c_ox_r * c_ox_r;
      s_sqz_r <= c_oz_r * c_oz_r;
      s_cx_r  <= c_cx_r;
      s_cz_r  <= c_cz_r;
      s_reg_r <= c_reg_r;
    end
  end

  // Output register.
  logic                 out_valid_r;
  logic [LB-1:0]        dist_r;
  logic signed [CB-1:0] ocx_r, ocz_r;
  logic [1:0]           oreg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= LB'($unsigned(s_sqx_r) + $unsigned(s_sqz_r));
      ocx_r  <= s_cx_r;
      ocz_r  <= s_cz_r;
      oreg_r <= s_reg_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign distance_squared = dist_r;
  assign closest_x        = ocx_r;
  assign closest_z        = ocz_r;
  assign region           = oreg_r;

endmodule

[hw/rtl/xz_point_segment_distance_closest.sv]
// Top level of the XZ point-to-segment distance block: register, front, queue, back.
// Depends on xzpsd_pkg, xzpsd_front, xzpsd_queue and xzpsd_back.
//
//   Channel   Signals                                   Direction
//   in        in_valid/in_ready, in_point_x..in_end_z   request in
//   out       out_valid/out_ready, out_distance_squared, out_closest_x/z, out_region
//   cfg       cfg_valid/cfg_ready, cfg_data             threshold write
//
// One request is accepted per cycle and one result leaves per cycle unless stalled.
// The front has difference, product and sum stages; the back has the 31-stage
// restoring divider for t, then multiply, closest point, square and output stages.
// Reset is synchronous and active low; it empties all stages and the queue and
// restores the threshold. A stalled output holds the back part, and a full
// queue then holds the front part and drops in_ready.
module xz_point_segment_distance_closest #(
  parameter int COORD_BITS = xzpsd_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_point_x,
  input  logic signed [COORD_BITS-1:0]       in_point_z,
  input  logic signed [COORD_BITS-1:0]       in_start_x,
  input  logic signed [COORD_BITS-1:0]       in_start_z,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2*COORD_BITS+2-1:0]          out_distance_squared,
  output logic signed [COORD_BITS-1:0]       out_closest_x,
  output logic signed [COORD_BITS-1:0]       out_closest_z,
  output logic [1:0]                         out_region,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [xzpsd_pkg::THRESH_BITS-1:0]  cfg_data
);
  localparam int CB  = COORD_BITS;
  localparam int DB  = CB + 1;
  localparam int LB  = 2 * CB + 2;
  localparam int SBW = 4 * CB + 2 * DB + 2;
  localparam int QW  = SBW + 2 * LB;

  logic [xzpsd_pkg::THRESH_BITS-1:0] thresh_r;
  xzpsd_pkg::q_wr_t q_wr;
  logic             q_full, q_empty, q_pop;
  logic [SBW-1:0]   f_side, b_side;
  logic [LB-1:0]    f_d1, f_len, b_d1, b_len;

  // Threshold register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= xzpsd_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  xzpsd_front #(.COORD_BITS(CB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (in_point_x),
    .point_z   (in_point_z),
    .start_x   (in_start_x),
    .start_z   (in_start_z),
    .end_x     (in_end_x),
    .end_z     (in_end_z),
    .threshold (thresh_r),
    .q_wr_o    (q_wr),
    .q_full    (q_full),
    .q_side    (f_side),
    .q_d1      (f_d1),
    .q_len     (f_len)
  );

  xzpsd_queue #(.WIDTH(QW), .DEPTH(xzpsd_pkg::QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr_i  (q_wr),
    .full    (q_full),
    .wr_data ({f_side, f_d1, f_len}),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data ({b_side, b_d1, b_len})
  );

  xzpsd_back #(.COORD_BITS(CB)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_side           (b_side),
    .q_d1             (b_d1),
    .q_len            (b_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .distance_squared (out_distance_squared),
    .closest_x        (out_closest_x),
    .closest_z        (out_closest_z),
    .region           (out_region)
  );

endmodule
